/* rtl/triangle_face_normal_and_centroid_top_defines.svh */
// ----------------------------------------------------------------------------
// Triangle face normal and centroid: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_AND_CENTROID_TOP_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_AND_CENTROID_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TFNC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// condition holds on every clock outside reset
`define TFNC_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

`endif

/* rtl/tfnc_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle face normal and centroid package
// Widths, constants and the side-band word carried down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tfnc_pkg;

  localparam int CW   = 16;           // corner coordinate width
  localparam int F    = 14;           // normal fraction bits
  localparam int NW   = F + 2;        // normal output width
  localparam int DW   = CW + 1;       // edge vector width
  localparam int PW   = 2 * DW;       // cross partial product width
  localparam int XW   = PW + 1;       // cross component width (signed)
  localparam int MW   = XW - 2;       // cross magnitude width
  localparam int LOB  = (MW + 1) / 2; // low split of magnitude
  localparam int HIB  = MW - LOB;     // high split of magnitude
  localparam int SW   = 2 * MW;       // square width
  localparam int LW   = SW + 2;       // squared length width
  localparam int QW   = 2 * F + 1;    // quotient width
  localparam int RW   = F + 1;        // root width
  localparam int TW   = CW + 3;       // biased centroid sum width
  localparam int KSH  = TW + 2;       // reciprocal shift
  localparam int LAT  = 6 + QW + RW + 1;

  localparam logic [TW-1:0] C_OFF   = TW'(3 * (2 ** CW) + 1);
  localparam logic [TW:0]   C_RECIP = (TW+1)'(((64'd1 << KSH) + 64'd2) / 64'd3);
  localparam logic signed [NW-1:0] NORM_ONE = NW'(2 ** F);

  typedef struct packed {
    logic [2:0][CW-1:0] center;
    logic [2:0]         neg;
    logic               deg;
  } side_t;

endpackage

`default_nettype wire

/* rtl/tfnc_front.sv */
// ----------------------------------------------------------------------------
// Front end
// Edge vectors, cross product, centroid, squared components and length.
// ----------------------------------------------------------------------------
`default_nettype none

module tfnc_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [2:0][tfnc_pkg::CW-1:0]     a_i,
  input  logic [2:0][tfnc_pkg::CW-1:0]     b_i,
  input  logic [2:0][tfnc_pkg::CW-1:0]     c_i,
  output logic                             valid_o,
  output logic [2:0][tfnc_pkg::SW-1:0]     sq_o,
  output logic [tfnc_pkg::LW-1:0]          len2_o,
  output tfnc_pkg::side_t                  side_o
);
  import tfnc_pkg::*;

  logic [5:0] vld_q;

  // stage 1
  logic signed [DW-1:0] u_q [3];
  logic signed [DW-1:0] v_q [3];
  logic [TW-1:0]        t_q [3];
  // stage 2
  logic signed [PW-1:0] p_q [6];
  logic [2*TW:0]        cp_q [3];
  // stage 3
  logic [2:0][MW-1:0]   mag_q;
  side_t                sd3_q;
  // stage 4
  logic [2*HIB-1:0]     hh_q [3];
  logic [HIB+LOB-1:0]   hl_q [3];
  logic [2*LOB-1:0]     ll_q [3];
  side_t                sd4_q;
  // stage 5
  logic [2:0][SW-1:0]   sq5_q;
  side_t                sd5_q;
  // stage 6
  logic [2:0][SW-1:0]   sq6_q;
  logic [LW-1:0]        len2_q;
  side_t                sd6_q;

  logic signed [XW-1:0] n_d [3];
  side_t                sd3_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      u_q[i] <= DW'($signed(c_i[i])) - DW'($signed(a_i[i]));
      v_q[i] <= DW'($signed(c_i[i])) - DW'($signed(b_i[i]));
      t_q[i] <= TW'($signed(a_i[i])) + TW'($signed(b_i[i])) + TW'($signed(c_i[i]))
                + C_OFF;
      cp_q[i] <= (2*TW+1)'(t_q[i]) * (2*TW+1)'(C_RECIP);
    end
    p_q[0] <= u_q[1] * v_q[2];
    p_q[1] <= u_q[2] * v_q[1];
    p_q[2] <= u_q[2] * v_q[0];
    p_q[3] <= u_q[0] * v_q[2];
    p_q[4] <= u_q[0] * v_q[1];
    p_q[5] <= u_q[1] * v_q[0];
  end

  always_comb begin
    sd3_d = '0;
    for (int i = 0; i < 3; i++) begin
      n_d[i] = XW'(p_q[2*i]) - XW'(p_q[2*i+1]);
      sd3_d.neg[i]    = n_d[i][XW-1];
      sd3_d.center[i] = cp_q[i][KSH+CW-1:KSH];
    end
    sd3_d.deg = (n_d[0] == '0) && (n_d[1] == '0) && (n_d[2] == '0);
  end

  always_ff @(posedge clk_i) begin
    sd3_q <= sd3_d;
    for (int i = 0; i < 3; i++) begin
      mag_q[i] <= n_d[i][XW-1] ? MW'(-n_d[i]) : MW'(n_d[i]);
      hh_q[i]  <= mag_q[i][MW-1:LOB] * mag_q[i][MW-1:LOB];
      hl_q[i]  <= mag_q[i][MW-1:LOB] * mag_q[i][LOB-1:0];
      ll_q[i]  <= mag_q[i][LOB-1:0] * mag_q[i][LOB-1:0];
      sq5_q[i] <= (SW'(hh_q[i]) << (2*LOB)) + (SW'(hl_q[i]) << (LOB+1)) + SW'(ll_q[i]);
    end
    sd4_q  <= sd3_q;
    sd5_q  <= sd4_q;
    sq6_q  <= sq5_q;
    len2_q <= LW'(sq5_q[0]) + LW'(sq5_q[1]) + LW'(sq5_q[2]);
    sd6_q  <= sd5_q;
  end

  assign valid_o = vld_q[5];
  assign sq_o    = sq6_q;
  assign len2_o  = len2_q;
  assign side_o  = sd6_q;

endmodule

`default_nettype wire

/* rtl/tfnc_div.sv */
// ----------------------------------------------------------------------------
// Ratio divider
// Restoring division of each square by the squared length, one quotient
// bit per stage, three channels side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module tfnc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [2:0][tfnc_pkg::SW-1:0]  sq_i,
  input  logic [tfnc_pkg::LW-1:0]       len2_i,
  input  tfnc_pkg::side_t               side_i,
  output logic                          valid_o,
  output logic [2:0][tfnc_pkg::QW-1:0]  quo_o,
  output tfnc_pkg::side_t               side_o
);
  import tfnc_pkg::*;

  logic [LW-1:0] rem_q [QW][3];
  logic [QW-1:0] quo_q [QW][3];
  logic [LW-1:0] den_q [QW];
  side_t         sd_q  [QW];
  logic [QW-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stg
    logic [LW-1:0] r_in [3];
    logic [QW-1:0] q_in [3];
    logic [LW-1:0] den_in;
    side_t         sd_in;

    if (s == 0) begin : g_head
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          r_in[i] = LW'(sq_i[i]);
          q_in[i] = '0;
        end
        den_in = len2_i;
        sd_in  = side_i;
      end
    end else begin : g_body
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          r_in[i] = rem_q[s-1][i];
          q_in[i] = quo_q[s-1][i];
        end
        den_in = den_q[s-1];
        sd_in  = sd_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[s] <= den_in;
      sd_q[s]  <= sd_in;
    end

    for (genvar i = 0; i < 3; i++) begin : g_ch
      logic [LW:0] t;
      logic [LW:0] diff;
      logic        qbit;
      assign t    = (s == 0) ? {1'b0, r_in[i]} : {r_in[i], 1'b0};
      assign diff = t - {1'b0, den_in};
      assign qbit = (t >= {1'b0, den_in});
      always_ff @(posedge clk_i) begin
        rem_q[s][i] <= qbit ? diff[LW-1:0] : t[LW-1:0];
        quo_q[s][i] <= {q_in[i][QW-2:0], qbit};
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign side_o  = sd_q[QW-1];
  for (genvar i = 0; i < 3; i++) begin : g_out
    assign quo_o[i] = quo_q[QW-1][i];
  end

endmodule

`default_nettype wire

/* rtl/tfnc_sqrt.sv */
// ----------------------------------------------------------------------------
// Integer square root
// Floor root of each quotient, one result bit per stage, three channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tfnc_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [2:0][tfnc_pkg::QW-1:0]  rad_i,
  input  tfnc_pkg::side_t               side_i,
  output logic                          valid_o,
  output logic [2:0][tfnc_pkg::RW-1:0]  root_o,
  output tfnc_pkg::side_t               side_o
);
  import tfnc_pkg::*;

  logic [QW-1:0] rad_q  [RW][3];
  logic [RW-1:0] root_q [RW][3];
  side_t         sd_q   [RW];
  logic [RW-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[RW-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < RW; s++) begin : g_stg
    logic [QW-1:0] r_in [3];
    logic [RW-1:0] q_in [3];
    side_t         sd_in;

    if (s == 0) begin : g_head
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          r_in[i] = rad_i[i];
          q_in[i] = '0;
        end
        sd_in = side_i;
      end
    end else begin : g_body
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          r_in[i] = rad_q[s-1][i];
          q_in[i] = root_q[s-1][i];
        end
        sd_in = sd_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      sd_q[s] <= sd_in;
    end

    for (genvar i = 0; i < 3; i++) begin : g_ch
      logic [RW-1:0]   cand;
      logic [2*RW-1:0] csq;
      assign cand = q_in[i] | (RW'(1) << (RW - 1 - s));
      assign csq  = (2*RW)'(cand) * (2*RW)'(cand);
      always_ff @(posedge clk_i) begin
        rad_q[s][i]  <= r_in[i];
        root_q[s][i] <= (csq <= (2*RW)'(r_in[i])) ? cand : q_in[i];
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign side_o  = sd_q[RW-1];
  for (genvar i = 0; i < 3; i++) begin : g_out
    assign root_o[i] = root_q[RW-1][i];
  end

endmodule

`default_nettype wire

/* rtl/triangle_face_normal_and_centroid_top.sv */
// ----------------------------------------------------------------------------
// Triangle face normal and centroid
// A triangle given by three corners enters when start is high; its
// centroid and unit normal (Q1.14, zero for a degenerate triangle)
// appear for one cycle with valid_o. A new triangle is taken every
// cycle and busy stays low. The path runs through 6 front stages, 29
// divider stages (one quotient bit each), 15 square root stages and the
// output register. The receiver cannot stall the block.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal_and_centroid_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [tfnc_pkg::CW-1:0]       a_x_i,
  input  logic [tfnc_pkg::CW-1:0]       a_y_i,
  input  logic [tfnc_pkg::CW-1:0]       a_z_i,
  input  logic [tfnc_pkg::CW-1:0]       b_x_i,
  input  logic [tfnc_pkg::CW-1:0]       b_y_i,
  input  logic [tfnc_pkg::CW-1:0]       b_z_i,
  input  logic [tfnc_pkg::CW-1:0]       c_x_i,
  input  logic [tfnc_pkg::CW-1:0]       c_y_i,
  input  logic [tfnc_pkg::CW-1:0]       c_z_i,
  output logic                          valid_o,
  output logic [tfnc_pkg::CW-1:0]       center_x_o,
  output logic [tfnc_pkg::CW-1:0]       center_y_o,
  output logic [tfnc_pkg::CW-1:0]       center_z_o,
  output logic [tfnc_pkg::NW-1:0]       normal_x_o,
  output logic [tfnc_pkg::NW-1:0]       normal_y_o,
  output logic [tfnc_pkg::NW-1:0]       normal_z_o,
  output logic                          degenerate_o
);
  import tfnc_pkg::*;

  logic               fr_vld;
  logic [2:0][SW-1:0] fr_sq;
  logic [LW-1:0]      fr_len2;
  side_t              fr_sd;
  logic               dv_vld;
  logic [2:0][QW-1:0] dv_quo;
  side_t              dv_sd;
  logic               sr_vld;
  logic [2:0][RW-1:0] sr_root;
  side_t              sr_sd;
  logic [NW-1:0]      nrm_d [3];
  logic               accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  tfnc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .a_i     ({a_z_i, a_y_i, a_x_i}),
    .b_i     ({b_z_i, b_y_i, b_x_i}),
    .c_i     ({c_z_i, c_y_i, c_x_i}),
    .valid_o (fr_vld),
    .sq_o    (fr_sq),
    .len2_o  (fr_len2),
    .side_o  (fr_sd)
  );

  tfnc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_vld),
    .sq_i    (fr_sq),
    .len2_i  (fr_len2),
    .side_i  (fr_sd),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .side_o  (dv_sd)
  );

  tfnc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_vld),
    .rad_i   (dv_quo),
    .side_i  (dv_sd),
    .valid_o (sr_vld),
    .root_o  (sr_root),
    .side_o  (sr_sd)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sr_sd.deg) begin
        nrm_d[i] = '0;
      end else if (sr_sd.neg[i]) begin
        nrm_d[i] = NW'(-NW'(sr_root[i]));
      end else begin
        nrm_d[i] = NW'(sr_root[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= sr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    center_x_o   <= sr_sd.center[0];
    center_y_o   <= sr_sd.center[1];
    center_z_o   <= sr_sd.center[2];
    normal_x_o   <= nrm_d[0];
    normal_y_o   <= nrm_d[1];
    normal_z_o   <= nrm_d[2];
    degenerate_o <= sr_sd.deg;
  end

endmodule

`default_nettype wire

/* rtl/tfnc_checker.sv */
// ----------------------------------------------------------------------------
// Port checker
// Watches the result port of the triangle block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_face_normal_and_centroid_top_defines.svh"

module tfnc_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     busy,
  input  logic                     valid_o,
  input  logic [tfnc_pkg::NW-1:0]  normal_x_o,
  input  logic [tfnc_pkg::NW-1:0]  normal_y_o,
  input  logic [tfnc_pkg::NW-1:0]  normal_z_o,
  input  logic                     degenerate_o
);
  import tfnc_pkg::*;

  logic zero_n;
  logic in_range;

  assign zero_n   = (normal_x_o == '0) && (normal_y_o == '0) && (normal_z_o == '0);
  assign in_range = ($signed(normal_x_o) <= NORM_ONE) && ($signed(normal_x_o) >= -NORM_ONE)
                 && ($signed(normal_y_o) <= NORM_ONE) && ($signed(normal_y_o) >= -NORM_ONE)
                 && ($signed(normal_z_o) <= NORM_ONE) && ($signed(normal_z_o) >= -NORM_ONE);

  `TFNC_ASSERT_ALWAYS(a_never_busy, clk_i, rst_ni, !busy, "busy raised")
  `TFNC_ASSERT_IMP(a_deg_zero, clk_i, rst_ni, valid_o && degenerate_o, zero_n, "degenerate word with nonzero normal")
  `TFNC_ASSERT_IMP(a_norm_nonzero, clk_i, rst_ni, valid_o && !degenerate_o, !zero_n, "zero normal without degenerate")
  `TFNC_ASSERT_IMP(a_norm_range, clk_i, rst_ni, valid_o, in_range, "normal component out of range")

endmodule

bind triangle_face_normal_and_centroid_top tfnc_checker u_tfnc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .busy         (busy),
  .valid_o      (valid_o),
  .normal_x_o   (normal_x_o),
  .normal_y_o   (normal_y_o),
  .normal_z_o   (normal_z_o),
  .degenerate_o (degenerate_o)
);

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Triangle face normal and centroid testbench
// Drives triangles in bursts, predicts centroid and unit normal with exact
// integer math or directed rows, and checks every output word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import tfnc_pkg::*;

  typedef struct {
    logic [CW-1:0] cx, cy, cz;
    logic [NW-1:0] nx, ny, nz;
    logic          deg;
  } face_t;

  typedef struct {
    logic [CW-1:0] c [9];
    bit            has_exp;
    logic [CW-1:0] ecx, ecy, ecz;
    logic [NW-1:0] enx, eny, enz;
    logic          edeg;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CW-1:0] crn [9];
  logic valid_o, degenerate_o;
  logic [CW-1:0] center_x_o, center_y_o, center_z_o;
  logic [NW-1:0] normal_x_o, normal_y_o, normal_z_o;

  face_t expected_faces [$];
  row_t  dir_rows [$];
  int    fails = 0;

  triangle_face_normal_and_centroid_top i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .a_x_i(crn[0]), .a_y_i(crn[1]), .a_z_i(crn[2]),
    .b_x_i(crn[3]), .b_y_i(crn[4]), .b_z_i(crn[5]),
    .c_x_i(crn[6]), .c_y_i(crn[7]), .c_z_i(crn[8]),
    .valid_o, .center_x_o, .center_y_o, .center_z_o,
    .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("triangle_face_normal_and_centroid_top: mismatch");
    $finish;
  end

  function automatic logic [CW-1:0] mean3(logic signed [CW-1:0] p, q, r);
    longint s;
    s = longint'(p) + longint'(q) + longint'(r) + 1;
    s = (s + (longint'(3) << 40)) / 3 - (longint'(1) << 40);
    return CW'(s);
  endfunction

  function automatic logic [NW-1:0] unit_comp(longint n, logic [127:0] len2);
    logic [127:0] mag, rhs;
    logic [63:0]  q, cand;
    mag = (n < 0) ? -n : n;
    rhs = (mag * mag) << (2 * F);
    q = 0;
    for (int b = F; b >= 0; b--) begin
      cand = q | (64'd1 << b);
      if (128'(cand * cand) * len2 <= rhs) q = cand;
    end
    if (n < 0) q = -q;
    return NW'(q);
  endfunction

  function automatic face_t predict_face(logic [CW-1:0] c [9]);
    face_t f;
    longint v [9];
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic [127:0] l2, ax, ay, az;
    for (int i = 0; i < 9; i++) v[i] = longint'(signed'(c[i]));
    f.cx = mean3(c[0], c[3], c[6]);
    f.cy = mean3(c[1], c[4], c[7]);
    f.cz = mean3(c[2], c[5], c[8]);
    ux = v[6] - v[0]; uy = v[7] - v[1]; uz = v[8] - v[2];
    vx = v[6] - v[3]; vy = v[7] - v[4]; vz = v[8] - v[5];
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    ax = (nx < 0) ? -nx : nx;
    ay = (ny < 0) ? -ny : ny;
    az = (nz < 0) ? -nz : nz;
    l2 = ax * ax + ay * ay + az * az;
    f.deg = (l2 == 0);
    if (f.deg) begin
      f.nx = '0; f.ny = '0; f.nz = '0;
    end else begin
      f.nx = unit_comp(nx, l2);
      f.ny = unit_comp(ny, l2);
      f.nz = unit_comp(nz, l2);
    end
    return f;
  endfunction

  task automatic chk(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s expected %0h actual %0h", nm, e, a);
      fails++;
    end
  endtask

  // output monitor
  initial begin
    face_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && valid_o === 1'b1) begin
        if (expected_faces.size() == 0) begin
          $error("unexpected word");
          fails++;
        end else begin
          e = expected_faces.pop_front();
          chk("center_x", e.cx, center_x_o);
          chk("center_y", e.cy, center_y_o);
          chk("center_z", e.cz, center_z_o);
          chk("normal_x", e.nx, normal_x_o);
          chk("normal_y", e.ny, normal_y_o);
          chk("normal_z", e.nz, normal_z_o);
          chk("degenerate", e.deg, degenerate_o);
        end
      end
    end
  end

  int burst_left = 0;

  // one word per call; random gaps between bursts
  task automatic send_face(logic [CW-1:0] c [9], face_t f);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    for (int i = 0; i < 9; i++) crn[i] <= c[i];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_faces = {expected_faces, f};
    @(negedge clk_i);
  endtask

  function automatic row_t mk(int a0, a1, a2, a3, a4, a5, a6, a7, a8);
    row_t r;
    r.c = '{CW'(a0), CW'(a1), CW'(a2), CW'(a3), CW'(a4), CW'(a5), CW'(a6), CW'(a7),
            CW'(a8)};
    r.has_exp = 0;
    return r;
  endfunction

  function automatic row_t mkx(row_t r, int cx, cy, cz, nx, ny, nz, bit dg);
    r.has_exp = 1;
    r.ecx = CW'(cx); r.ecy = CW'(cy); r.ecz = CW'(cz);
    r.enx = NW'(nx); r.eny = NW'(ny); r.enz = NW'(nz); r.edeg = dg;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  initial begin
    row_t  r;
    face_t f;
    logic [CW-1:0] c [9];
    int    mode, k;
    for (int i = 0; i < 9; i++) crn[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    add_row(mkx(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0, 1));
    add_row(mkx(mk(0, 0, 0, 256, 0, 0, 0, 256, 0), 85, 85, 0, 0, 0, 16384, 0));
    add_row(mkx(mk(0, 0, 0, 0, 256, 0, 256, 0, 0), 85, 85, 0, 0, 0, -16384, 0));
    add_row(mkx(mk(0, 0, 0, 0, 0, 256, 0, 256, 0), 0, 85, 85, -16384, 0, 0, 0));
    add_row(mkx(mk(0, 0, 0, 256, 0, 0, 0, 0, 256), 85, 0, 85, 0, -16384, 0, 0));
    add_row(mkx(mk(1, 1, 1, 2, 2, 2, 3, 3, 3), 2, 2, 2, 0, 0, 0, 1));
    add_row(mkx(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
                32767, 32767, 32767, 0, 0, 0, 1));
    add_row(mkx(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                   -32768), -32768, -32768, -32768, 0, 0, 0, 1));
    add_row(mk(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, 32767));
    add_row(mk(32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768, 32767));
    add_row(mk(-32768, 32767, 0, 32767, -32768, 0, 0, 0, 32767));
    add_row(mkx(mk(1, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0, 1));
    add_row(mkx(mk(2, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0, 0, 1));
    add_row(mk(0, 0, 0, 1, 0, 0, 0, 1, 1));
    add_row(mk(-1, -1, -1, 1, 2, 3, 5, -7, 11));
    add_row(mk(0, 0, 0, 32767, 1, 0, -32768, 1, 1));

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      f = predict_face(r.c);
      if (r.has_exp) begin
        f.cx = r.ecx; f.cy = r.ecy; f.cz = r.ecz;
        f.nx = r.enx; f.ny = r.eny; f.nz = r.enz; f.deg = r.edeg;
      end
      send_face(r.c, f);
    end

    for (int n = 0; n < 1200; n++) begin
      if (n == 600) begin
        start <= 1'b0;
        burst_left = 0;
        while (expected_faces.size() != 0) @(negedge clk_i);
      end
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
        case (mode)
          0, 1:    c[i] = CW'($urandom_range(0, 15) - 8);
          2:       c[i] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
          default: c[i] = CW'($urandom);
        endcase
      end
      if (mode == 3) begin
        // repeated corner
        k = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) c[3*k + i] = c[3*((k + 1) % 3) + i];
      end
      send_face(c, predict_face(c));
    end
    start <= 1'b0;

    while (expected_faces.size() != 0) @(negedge clk_i);
    repeat (LAT + 10) @(negedge clk_i);
    if (fails == 0) begin
      $display("triangle_face_normal_and_centroid_top: match");
    end else begin
      $display("triangle_face_normal_and_centroid_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
